// ===== rtl/mavg_pkg.sv =====
// Shared types and constants for the moving average alarm monitor.
// Holds the controller state type, the command and status structs and the register codes.
// No dependencies.
`timescale 1ns / 1ps

package mavg_pkg;

   localparam int DATA_W = 16;
   localparam int BAND_W = 15;
   localparam int CSR_IDX_W = 2;
   localparam int COUNT_W = 32;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HYSTERESIS = 2'd1;

   // Reset values of the registers and the running extremes.
   localparam logic signed [DATA_W-1:0] THRESHOLD_RST = 16'sd4500;
   localparam logic [BAND_W-1:0] BAND_RST = 15'd200;
   localparam logic signed [DATA_W-1:0] LOWEST_RST = 16'sh7fff;
   localparam logic signed [DATA_W-1:0] HIGHEST_RST = 16'sh8000;

   // Alarm transition codes.
   localparam logic [1:0] CHANGE_NONE = 2'd0;
   localparam logic [1:0] CHANGE_RAISED = 2'd1;
   localparam logic [1:0] CHANGE_CLEARED = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_MEAN,
      ST_ALARM,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic update;
      logic div_init;
      logic div_step;
      logic mean;
      logic alarm;
      logic publish;
   } dp_cmd_type;

   typedef struct packed {
      logic div_last;
   } dp_status_type;

endpackage

// ===== rtl/moving_average_alarm_monitor_core.sv =====
// Top level of the moving average alarm monitor: ties the controller to the datapath.
// Depends on mavg_pkg, mavg_ctrl and mavg_dp.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake              Contents
//  req_      in         req_valid/req_ready    one temperature sample word
//  rsp_      out        rsp_valid/rsp_ready    mean, extremes, alarm state and counters
//  csr_      in         csr_valid/csr_ready    register index and write data
//
//  Each sample word passes through the update, divider start, divider step, mean, alarm and
//  finish states from acceptance to its result, and the next word is taken only once the
//  sequencer is back in idle, so words do not overlap; the serial divider, one quotient bit
//  per cycle over the full width of the running sum, is the longest of these steps.
//  The input side is ready again once the previous result is in the output register, so a
//  new word is taken while that result still waits for rsp_ready.
//  Reset is synchronous and active high; the sample ring needs no clearing pass because an
//  entry is only used after the window has filled.
//  A stalled result holds the sequencer in its final state until the output register frees.

module moving_average_alarm_monitor_core #(
   parameter int WINDOW = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [mavg_pkg::DATA_W-1:0]   req_sample_x100,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [mavg_pkg::DATA_W-1:0]   rsp_mean_x100,
   output logic signed [mavg_pkg::DATA_W-1:0]   rsp_min_x100,
   output logic signed [mavg_pkg::DATA_W-1:0]   rsp_max_x100,
   output logic                                 rsp_alarm_on,
   output logic [1:0]                           rsp_alarm_change,
   output logic [mavg_pkg::COUNT_W-1:0]         rsp_alarm_total,
   output logic [mavg_pkg::COUNT_W-1:0]         rsp_sample_total,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mavg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mavg_pkg::DATA_W-1:0]          csr_wdata
);

   mavg_pkg::dp_cmd_type cmd;
   mavg_pkg::dp_status_type status;

   // Register writes are taken in any cycle outside reset; the user must issue them only while
   // no word is in flight, which the block does not enforce; the index selects threshold or band.
   assign csr_ready = !reset;

   // The controller owns the handshake flags and issues one command per step.
   mavg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the ring, running statistics, divider and result registers.
   mavg_dp #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample_x100  (req_sample_x100),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_mean_x100    (rsp_mean_x100),
      .rsp_min_x100     (rsp_min_x100),
      .rsp_max_x100     (rsp_max_x100),
      .rsp_alarm_on     (rsp_alarm_on),
      .rsp_alarm_change (rsp_alarm_change),
      .rsp_alarm_total  (rsp_alarm_total),
      .rsp_sample_total (rsp_sample_total)
   );

endmodule

// ===== rtl/mavg_ctrl.sv =====
// Controller state machine of the moving average alarm monitor.
// Sequences load, update, divide, alarm and publish; owns the handshake flags.
// Depends on mavg_pkg.
`timescale 1ns / 1ps

module mavg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  mavg_pkg::dp_status_type status,
   output mavg_pkg::dp_cmd_type   cmd
);

   mavg_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mavg_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = mavg_pkg::ST_UPDATE;
            end
         end
         mavg_pkg::ST_UPDATE:   state_in = mavg_pkg::ST_DIV_INIT;
         mavg_pkg::ST_DIV_INIT: state_in = mavg_pkg::ST_DIV_STEP;
         mavg_pkg::ST_DIV_STEP: begin
            if (status.div_last) begin
               state_in = mavg_pkg::ST_MEAN;
            end
         end
         mavg_pkg::ST_MEAN:     state_in = mavg_pkg::ST_ALARM;
         mavg_pkg::ST_ALARM:    state_in = mavg_pkg::ST_FINISH;
         mavg_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = mavg_pkg::ST_IDLE;
            end
         end
         default:               state_in = mavg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         mavg_pkg::ST_IDLE: begin
            req_ready = !reset;
            cmd.load = req_valid && !reset;
         end
         mavg_pkg::ST_UPDATE:   cmd.update = 1'b1;
         mavg_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
         mavg_pkg::ST_DIV_STEP: cmd.div_step = 1'b1;
         mavg_pkg::ST_MEAN:     cmd.mean = 1'b1;
         mavg_pkg::ST_ALARM:    cmd.alarm = 1'b1;
         mavg_pkg::ST_FINISH:   cmd.publish = slot_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mavg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_starts_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mavg_pkg::ST_IDLE && req_valid) |=> state_ff == mavg_pkg::ST_UPDATE)
      else $error("accepted word did not start an update");

   a_divide_ends_in_mean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mavg_pkg::ST_DIV_STEP && status.div_last) |=> state_ff == mavg_pkg::ST_MEAN)
      else $error("divider did not hand over to the mean step");

   a_publish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> (rsp_valid_ff && state_ff == mavg_pkg::ST_IDLE))
      else $error("publish did not present a result word");

endmodule

// ===== rtl/mavg_dp.sv =====
// Datapath of the moving average alarm monitor: sample ring, running sum,
// serial divider, extremes, alarm logic, configuration and result registers.
// Depends on mavg_pkg.
`timescale 1ns / 1ps

module mavg_dp #(
   parameter int WINDOW = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  mavg_pkg::dp_cmd_type                    cmd,
   output mavg_pkg::dp_status_type                 status,
   input  logic signed [mavg_pkg::DATA_W-1:0]      req_sample_x100,
   input  logic                                    csr_write,
   input  logic [mavg_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [mavg_pkg::DATA_W-1:0]             csr_wdata,
   output logic signed [mavg_pkg::DATA_W-1:0]      rsp_mean_x100,
   output logic signed [mavg_pkg::DATA_W-1:0]      rsp_min_x100,
   output logic signed [mavg_pkg::DATA_W-1:0]      rsp_max_x100,
   output logic                                    rsp_alarm_on,
   output logic [1:0]                              rsp_alarm_change,
   output logic [mavg_pkg::COUNT_W-1:0]            rsp_alarm_total,
   output logic [mavg_pkg::COUNT_W-1:0]            rsp_sample_total
);

   localparam int DW = mavg_pkg::DATA_W;
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = DW + 1 + $clog2(WINDOW);
   localparam int STEP_W = $clog2(SUM_W);
   localparam int CMP_W = DW + 2;

   // Sample ring and its read port.
   logic signed [DW-1:0] ring_mem [WINDOW];
   logic signed [DW-1:0] old_ff;
   logic signed [DW-1:0] sample_ff;

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [DW-1:0] low_ff, low_in;
   logic signed [DW-1:0] high_ff, high_in;
   logic [mavg_pkg::COUNT_W-1:0] samples_ff, samples_in;
   logic window_full;

   // Divider.
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic neg_ff, neg_in;
   logic [CNT_W:0] trial;
   logic trial_ok;

   // Mean and alarm.
   logic signed [DW-1:0] mean_ff, mean_in;
   logic alarm_ff, alarm_in;
   logic [1:0] change_ff, change_in;
   logic [mavg_pkg::COUNT_W-1:0] alarms_ff, alarms_in;
   logic signed [CMP_W-1:0] mean_ext, thr_ext, clear_level;

   // Configuration.
   logic signed [DW-1:0] thr_ff;
   logic [mavg_pkg::BAND_W-1:0] band_ff;

   // Result registers.
   logic signed [DW-1:0] out_mean_ff, out_min_ff, out_max_ff;
   logic out_alarm_ff;
   logic [1:0] out_change_ff;
   logic [mavg_pkg::COUNT_W-1:0] out_alarms_ff, out_samples_ff;

   assign window_full = (fill_ff == CNT_W'(WINDOW));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         old_ff <= ring_mem[slot_ff];
         sample_ff <= req_sample_x100;
      end
      if (cmd.update) begin
         ring_mem[slot_ff] <= sample_ff;
      end
   end

   always_comb begin
      slot_in = slot_ff;
      fill_in = fill_ff;
      sum_in = sum_ff;
      low_in = low_ff;
      high_in = high_ff;
      samples_in = samples_ff;
      if (cmd.update) begin
         slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
         if (!window_full) begin
            fill_in = fill_ff + 1'b1;
         end
         sum_in = sum_ff - (window_full ? SUM_W'(old_ff) : '0) + SUM_W'(sample_ff);
         if (sample_ff < low_ff) begin
            low_in = sample_ff;
         end
         if (sample_ff > high_ff) begin
            high_in = sample_ff;
         end
         samples_in = samples_ff + 1'b1;
      end
   end

   // Restoring division of the sum magnitude by the fill count, one bit a cycle.
   assign trial = {rem_ff, quo_ff[SUM_W-1]} - {1'b0, fill_ff};
   assign trial_ok = !trial[CNT_W];

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      neg_in = neg_ff;
      if (cmd.div_init) begin
         neg_in = sum_ff[SUM_W-1];
         quo_in = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
         rem_in = '0;
         step_in = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[SUM_W-2:0], trial_ok};
         rem_in = trial_ok ? trial[CNT_W-1:0] : CNT_W'({rem_ff, quo_ff[SUM_W-1]});
         step_in = step_ff + 1'b1;
      end
   end

   assign status.div_last = (step_ff == STEP_W'(SUM_W - 1));

   always_comb begin
      mean_in = mean_ff;
      if (cmd.mean) begin
         mean_in = neg_ff ? -$signed(quo_ff[DW-1:0]) : $signed(quo_ff[DW-1:0]);
      end
   end

   assign mean_ext = CMP_W'(mean_ff);
   assign thr_ext = CMP_W'(thr_ff);
   assign clear_level = thr_ext - $signed({3'b000, band_ff});

   always_comb begin
      alarm_in = alarm_ff;
      change_in = change_ff;
      alarms_in = alarms_ff;
      if (cmd.alarm) begin
         change_in = mavg_pkg::CHANGE_NONE;
         if (!alarm_ff && mean_ext > thr_ext) begin
            alarm_in = 1'b1;
            alarms_in = alarms_ff + 1'b1;
            change_in = mavg_pkg::CHANGE_RAISED;
         end else if (alarm_ff && mean_ext < clear_level) begin
            alarm_in = 1'b0;
            change_in = mavg_pkg::CHANGE_CLEARED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         fill_ff <= '0;
         sum_ff <= '0;
         low_ff <= mavg_pkg::LOWEST_RST;
         high_ff <= mavg_pkg::HIGHEST_RST;
         samples_ff <= '0;
         alarm_ff <= 1'b0;
         alarms_ff <= '0;
         change_ff <= mavg_pkg::CHANGE_NONE;
         step_ff <= '0;
         rem_ff <= '0;
      end else begin
         slot_ff <= slot_in;
         fill_ff <= fill_in;
         sum_ff <= sum_in;
         low_ff <= low_in;
         high_ff <= high_in;
         samples_ff <= samples_in;
         alarm_ff <= alarm_in;
         alarms_ff <= alarms_in;
         change_ff <= change_in;
         step_ff <= step_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      mean_ff <= mean_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= mavg_pkg::THRESHOLD_RST;
         band_ff <= mavg_pkg::BAND_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            mavg_pkg::CSR_THRESHOLD:  thr_ff <= $signed(csr_wdata);
            mavg_pkg::CSR_HYSTERESIS: band_ff <= csr_wdata[mavg_pkg::BAND_W-1:0];
            default: begin
               thr_ff <= thr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_mean_ff <= mean_ff;
         out_min_ff <= low_ff;
         out_max_ff <= high_ff;
         out_alarm_ff <= alarm_ff;
         out_change_ff <= change_ff;
         out_alarms_ff <= alarms_ff;
         out_samples_ff <= samples_ff;
      end
   end

   assign rsp_mean_x100 = out_mean_ff;
   assign rsp_min_x100 = out_min_ff;
   assign rsp_max_x100 = out_max_ff;
   assign rsp_alarm_on = out_alarm_ff;
   assign rsp_alarm_change = out_change_ff;
   assign rsp_alarm_total = out_alarms_ff;
   assign rsp_sample_total = out_samples_ff;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(WINDOW))
      else $error("fill count passed the window length");

   a_remainder_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < fill_ff)
      else $error("divider remainder not below the fill count");

   a_change_matches_flag: assert property (@(posedge clock) disable iff (reset)
      cmd.alarm |=> ((change_ff == mavg_pkg::CHANGE_NONE && alarm_ff == $past(alarm_ff))
         || (change_ff == mavg_pkg::CHANGE_RAISED && alarm_ff)
         || (change_ff == mavg_pkg::CHANGE_CLEARED && !alarm_ff)))
      else $error("alarm change code disagrees with the alarm flag");

endmodule

// ===== tb/sv/tb_moving_average_alarm_monitor_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for moving_average_alarm_monitor_core. It sends temperature
// sample words, predicts each result word in its own model and checks every field.
// Depends on mavg_pkg and the RTL of the monitor core; reads and writes no files.

module tb_moving_average_alarm_monitor_core;

   localparam int DW = mavg_pkg::DATA_W;
   localparam int CW = mavg_pkg::COUNT_W;
   localparam int IW = mavg_pkg::CSR_IDX_W;
   localparam int WIN = 8;
   // Indexes past the end of the register list; writes to them must change nothing.
   localparam logic [IW-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [IW-1:0] CSR_SPARE_B = 2'd3;
   localparam int SAMPLE_MIN = -32768;
   localparam int SAMPLE_MAX = 32767;
   localparam int WORDS_PER_BLOCK = 100;
   localparam int DRAIN_SLACK = 40;
   localparam int STALL_CYCLES = 400;

   // One expected result word.
   typedef struct {
      logic signed [DW-1:0] mean;
      logic signed [DW-1:0] lowest;
      logic signed [DW-1:0] highest;
      logic                 alarm_on;
      logic [1:0]           change;
      logic [CW-1:0]        raises;
      logic [CW-1:0]        samples;
   } reading_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [DW-1:0]       req_sample_x100 = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [DW-1:0]       rsp_mean_x100;
   logic signed [DW-1:0]       rsp_min_x100;
   logic signed [DW-1:0]       rsp_max_x100;
   logic                       rsp_alarm_on;
   logic [1:0]                 rsp_alarm_change;
   logic [CW-1:0]              rsp_alarm_total;
   logic [CW-1:0]              rsp_sample_total;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [IW-1:0]              csr_index = '0;
   logic [DW-1:0]              csr_wdata = '0;

   // Shadow of the monitor: sample history, extremes, alarm and the two registers.
   logic signed [DW-1:0]       hist_buf [WIN];
   int                         next_pos = 0;
   int                         hist_len = 0;
   int                         hist_sum = 0;
   logic signed [DW-1:0]       low_mark = mavg_pkg::LOWEST_RST;
   logic signed [DW-1:0]       high_mark = mavg_pkg::HIGHEST_RST;
   logic                       alarm_active = 1'b0;
   logic [CW-1:0]              raise_count = '0;
   logic [CW-1:0]              sample_count = '0;
   logic signed [DW-1:0]       thr_reg = mavg_pkg::THRESHOLD_RST;
   logic [mavg_pkg::BAND_W-1:0] band_reg = mavg_pkg::BAND_RST;
   int                         clear_count = 0;

   reading_type                pending_readings[$];
   int                         fail_count = 0;
   int                         words_checked = 0;
   int                         send_idle_pct = 0;
   int                         recv_idle_pct = 0;
   int                         stall_request = 0;
   int                         stall_left = 0;

   always #5 clock = ~clock;

   moving_average_alarm_monitor_core #(.WINDOW(WIN)) dut (.*);

   function automatic logic signed [DW-1:0] clamp16(input int v);
      if (v > SAMPLE_MAX) return DW'(SAMPLE_MAX);
      if (v < SAMPLE_MIN) return DW'(SAMPLE_MIN);
      return DW'(v);
   endfunction

   // Advances the shadow by one accepted sample and queues the result word it must give.
   function automatic void predict_reading(input logic signed [DW-1:0] s);
      reading_type r;
      int          mean;
      if (hist_len >= WIN) begin
         hist_sum -= hist_buf[next_pos];
      end else begin
         hist_len++;
      end
      hist_buf[next_pos] = s;
      hist_sum += s;
      next_pos = (next_pos + 1) % WIN;
      // Integer division in SystemVerilog truncates toward zero, as the block must.
      mean = hist_sum / hist_len;
      if (s < low_mark) low_mark = s;
      if (s > high_mark) high_mark = s;
      sample_count++;
      r.change = mavg_pkg::CHANGE_NONE;
      // The clear level is formed at full integer width, so it never wraps.
      if (!alarm_active && mean > int'(thr_reg)) begin
         alarm_active = 1'b1;
         raise_count++;
         r.change = mavg_pkg::CHANGE_RAISED;
      end else if (alarm_active && mean < int'(thr_reg) - int'(band_reg)) begin
         alarm_active = 1'b0;
         clear_count++;
         r.change = mavg_pkg::CHANGE_CLEARED;
      end
      r.mean = DW'(mean);
      r.lowest = low_mark;
      r.highest = high_mark;
      r.alarm_on = alarm_active;
      r.raises = raise_count;
      r.samples = sample_count;
      pending_readings.push_back(r);
   endfunction

   // Returns the sample that makes the next window mean equal the target, where it fits.
   function automatic logic signed [DW-1:0] aim_at(input int target);
      int n;
      int rest;
      if (hist_len >= WIN) begin
         n = WIN;
         rest = hist_sum - hist_buf[next_pos];
      end else begin
         n = hist_len + 1;
         rest = hist_sum;
      end
      return clamp16(target * n - rest);
   endfunction

   // Random sample: mostly close to the alarm levels so the alarm toggles often, some aimed
   // exactly at the raise and clear boundaries, and the rest full-range noise.
   function automatic logic signed [DW-1:0] pick_sample();
      int roll;
      int spread;
      int clear_level;
      roll = $urandom_range(99);
      spread = int'(band_reg) + 600;
      clear_level = int'(thr_reg) - int'(band_reg);
      if (roll < 20) return DW'($urandom);
      if (roll < 35) begin
         case ($urandom_range(3))
            0: return aim_at(int'(thr_reg));
            1: return aim_at(int'(thr_reg) + 1);
            2: return aim_at(clear_level);
            default: return aim_at(clear_level - 1);
         endcase
      end
      return clamp16(int'(thr_reg) + int'($urandom_range(2 * spread)) - spread);
   endfunction

   // Offers one sample word and returns at the edge where it is accepted. Valid stays high
   // afterwards, so back-to-back words drop it only for random idle gaps; settle() lowers it.
   task automatic send_sample(input logic signed [DW-1:0] s);
      csr_valid <= 1'b0;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_sample_x100 <= s;
      do @(posedge clock); while (!req_ready);
      predict_reading(s);
   endtask

   // Register write; only called while nothing is in flight.
   task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         mavg_pkg::CSR_THRESHOLD: thr_reg = data;
         mavg_pkg::CSR_HYSTERESIS: band_reg = data[mavg_pkg::BAND_W-1:0];
         default: ;
      endcase
   endtask

   // Drops both request channels and waits until every expected word has come back.
   task automatic settle();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      do @(posedge clock); while (pending_readings.size() != 0);
   endtask

   // Output side: random stalls at the current rate, or a long hold-off when one is asked for.
   always @(posedge clock) begin
      if (stall_request > 0) begin
         stall_left = stall_request;
         stall_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Every accepted result word is checked against the oldest expectation.
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked++;
         if (pending_readings.size() == 0) begin
            $error("result word arrived with no expectation waiting");
            fail_count++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_mean_x100 !== want.mean) begin
               $error("mean_x100: expected %0d, got %0d", want.mean, rsp_mean_x100);
               fail_count++;
            end
            if (rsp_min_x100 !== want.lowest) begin
               $error("min_x100: expected %0d, got %0d", want.lowest, rsp_min_x100);
               fail_count++;
            end
            if (rsp_max_x100 !== want.highest) begin
               $error("max_x100: expected %0d, got %0d", want.highest, rsp_max_x100);
               fail_count++;
            end
            if (rsp_alarm_on !== want.alarm_on) begin
               $error("alarm_on: expected %0d, got %0d", want.alarm_on, rsp_alarm_on);
               fail_count++;
            end
            if (rsp_alarm_change !== want.change) begin
               $error("alarm_change: expected %0d, got %0d", want.change, rsp_alarm_change);
               fail_count++;
            end
            if (rsp_alarm_total !== want.raises) begin
               $error("alarm_total: expected %0d, got %0d", want.raises, rsp_alarm_total);
               fail_count++;
            end
            if (rsp_sample_total !== want.samples) begin
               $error("sample_total: expected %0d, got %0d", want.samples, rsp_sample_total);
               fail_count++;
            end
         end
      end
   end

   // With the reset register values, the mean sits exactly on the raise level, one above it,
   // exactly on the clear level and one below it. The partial window makes aiming exact.
   task automatic test_reset_thresholds();
      send_sample(aim_at(int'(mavg_pkg::THRESHOLD_RST)));
      send_sample(aim_at(int'(mavg_pkg::THRESHOLD_RST) + 1));
      send_sample(aim_at(int'(mavg_pkg::THRESHOLD_RST) - int'(mavg_pkg::BAND_RST)));
      send_sample(aim_at(int'(mavg_pkg::THRESHOLD_RST) - int'(mavg_pkg::BAND_RST) - 1));
   endtask

   // The same four boundaries with newly written register values.
   task automatic test_alarm_hysteresis();
      settle();
      write_reg(mavg_pkg::CSR_THRESHOLD, DW'(1000));
      write_reg(mavg_pkg::CSR_HYSTERESIS, DW'(300));
      send_sample(aim_at(1000));
      send_sample(aim_at(1001));
      send_sample(aim_at(700));
      send_sample(aim_at(699));
   endtask

   // Register extremes: a threshold that cannot be exceeded with no band, then the lowest
   // threshold with the widest band, so the clear level goes far below the sample range.
   // The band write has its top data bit set, which the block must drop, and the spare
   // indexes are written to show they change nothing.
   task automatic test_register_extremes();
      settle();
      write_reg(mavg_pkg::CSR_THRESHOLD, 16'h7fff);
      write_reg(mavg_pkg::CSR_HYSTERESIS, 16'h0000);
      send_sample(DW'(SAMPLE_MAX));
      send_sample(DW'(SAMPLE_MAX));
      settle();
      write_reg(mavg_pkg::CSR_THRESHOLD, 16'h8000);
      write_reg(mavg_pkg::CSR_HYSTERESIS, 16'hffff);
      write_reg(CSR_SPARE_A, DW'($urandom));
      write_reg(CSR_SPARE_B, DW'($urandom));
      send_sample(DW'(SAMPLE_MIN));
      send_sample(DW'(SAMPLE_MIN));
   endtask

   // Extreme and near-zero samples, so the running sum swings across its whole range and
   // negative means must truncate toward zero.
   task automatic test_sample_extremes();
      logic signed [DW-1:0] picks [8] = '{16'sh8000, 16'sh8000, -16'sd1, 16'sd0,
                                          16'sd1, 16'sh7fff, 16'sh8000, -16'sd1};
      foreach (picks[i]) send_sample(picks[i]);
   endtask

   // Random traffic under one idle mix, in blocks with fresh register values between them.
   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      logic [DW-1:0] thr;
      logic [DW-1:0] band;
      for (int blk = 0; blk < 3; blk++) begin
         settle();
         send_idle_pct = send_pct;
         recv_idle_pct = recv_pct;
         case ($urandom_range(7))
            0: thr = 16'h8000;
            1: thr = 16'h7fff;
            default: thr = DW'($urandom_range(7000) - 2000);
         endcase
         case ($urandom_range(7))
            0: band = '0;
            1: band = 16'hffff;
            2: band = DW'($urandom);
            default: band = DW'($urandom_range(800));
         endcase
         write_reg(mavg_pkg::CSR_THRESHOLD, thr);
         write_reg(mavg_pkg::CSR_HYSTERESIS, band);
         if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B, DW'($urandom));
         repeat (WORDS_PER_BLOCK) send_sample(pick_sample());
      end
   endtask

   // The output side holds off for a long stretch while words keep coming, so the result
   // register and the sequencer fill and the input side must stall.
   task automatic test_output_backpressure();
      settle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_request = STALL_CYCLES;
      repeat (30) send_sample(pick_sample());
   endtask

   initial begin
      foreach (hist_buf[i]) hist_buf[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 10;
      recv_idle_pct = 30;
      test_reset_thresholds();
      test_alarm_hysteresis();
      test_register_extremes();
      test_sample_extremes();
      test_random_traffic(20, 78);
      test_random_traffic(78, 20);
      test_random_traffic(0, 0);
      test_output_backpressure();
      settle();
      // Any stray word after the last expected one shows up as an unexpected result.
      repeat (DRAIN_SLACK) @(posedge clock);
      fail_count += pending_readings.size();
      $display("Checked %0d result words for %0d samples: %0d alarm raisings, %0d clearings.",
               words_checked, sample_count, raise_count, clear_count);
      $display("Register extremes, spare indexes, three idle mixes and a long output stall.");
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/mavg_pkg.sv
rtl/mavg_ctrl.sv
rtl/mavg_dp.sv
rtl/moving_average_alarm_monitor_core.sv
tb/sv/tb_moving_average_alarm_monitor_core.sv
